// ===== rtl/fcsg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fcsg_pkg;

  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_STATUS = 3'd1,
    OP_P1_CLK = 3'd2,
    OP_P2_CLK = 3'd3,
    OP_TR_CLK = 3'd4,
    OP_NS_CLK = 3'd5,
    OP_FRAME  = 3'd6
  } op_e;

  // register offsets from the sound block base
  localparam logic [4:0] REG_P1_CTRL  = 5'h00;
  localparam logic [4:0] REG_P1_LEN   = 5'h03;
  localparam logic [4:0] REG_P2_CTRL  = 5'h04;
  localparam logic [4:0] REG_P2_LEN   = 5'h07;
  localparam logic [4:0] REG_TR_LEN   = 5'h0B;
  localparam logic [4:0] REG_NS_VOL   = 5'h0C;
  localparam logic [4:0] REG_NS_MODE  = 5'h0E;
  localparam logic [4:0] REG_NS_LEN   = 5'h0F;
  localparam logic [4:0] REG_ENABLES  = 5'h15;
  localparam logic [4:0] REG_FRAME    = 5'h17;

  localparam logic [7:0] LEN_TABLE [32] = '{
    8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
    8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
  };

  localparam logic [3:0] TRI_TABLE [32] = '{
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8,
    4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0,
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7
  };

  // bit i of each pattern is the output at step i
  localparam logic [15:0] DUTY_PAT [4] = '{16'h000C, 16'h003C, 16'h03FC, 16'hFFC3};

  localparam logic [4:0] P_VOL_RESET = 5'd15;
  localparam logic [13:0] LFSR_SEED  = 14'd1;
  localparam logic [2:0] FRAME_FIRST = 3'd1;

endpackage

`default_nettype wire

// ===== rtl/four_channel_sound_generator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | handshake                 | payload
// --------+---------------------------+------------------------------------------
// in      | in_valid_i / in_stall_o   | op_i, reg_offset_i, wdata_i
// out     | out_valid_o / out_stall_i | status_o, pulse1_level_o, pulse2_level_o,
//         |                           | tri_level_o, noise_level_o
//
// One item per cycle sustained while out_stall_i holds no result; a result is presented
// once its item has passed the input register, loaded at the transfer edge, and then
// the result register, updated together with the channel state when no stall holds it.
// Reset (rst_ni low, asynchronous) returns every channel to its power-up state.
// While a result is stalled one more item is held in the input register; only
// then does in_stall_o rise.
module four_channel_sound_generator_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire  [2:0]           op_i,
  input  wire  [4:0]           reg_offset_i,
  input  wire  [7:0]           wdata_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic [2:0]           status_o,
  output logic [5:0]           pulse1_level_o,
  output logic [5:0]           pulse2_level_o,
  output logic [3:0]           tri_level_o,
  output logic [4:0]           noise_level_o
);
  import fcsg_pkg::*;

  // input register
  logic       in_valid_q;
  logic [2:0] op_q;
  logic [4:0] off_q;
  logic [7:0] wdata_q;

  // channel state
  logic [1:0]  p1_duty_q, p1_duty_d, p2_duty_q, p2_duty_d;
  logic [4:0]  p1_vol_q, p1_vol_d, p2_vol_q, p2_vol_d;
  logic [3:0]  p1_step_q, p1_step_d, p2_step_q, p2_step_d;
  logic [7:0]  p1_len_q, p1_len_d, p2_len_q, p2_len_d;
  logic [7:0]  tr_len_q, tr_len_d, ns_len_q, ns_len_d;
  logic [4:0]  tr_step_q, tr_step_d;
  logic [4:0]  ns_vol_q, ns_vol_d;
  logic        ns_tap_q, ns_tap_d;
  logic [3:0]  ns_rate_q, ns_rate_d;
  logic [13:0] lfsr_q, lfsr_d;
  logic [3:0]  enables_q, enables_d;
  logic        five_mode_q, five_mode_d;
  logic [2:0]  frame_step_q, frame_step_d;

  // result register
  logic       out_valid_q;
  logic [2:0] status_q, status_d;
  logic [5:0] p1_lvl_q, p1_lvl_d, p2_lvl_q, p2_lvl_d;
  logic [3:0] tr_lvl_q, tr_lvl_d;
  logic [4:0] ns_lvl_q, ns_lvl_d;

  logic        adv;
  logic        out_busy;
  logic [7:0]  len_lookup;
  logic        lfsr_fb;
  logic [13:0] lfsr_next;
  logic [3:0]  frame_sum;

  assign out_busy   = out_valid_q & out_stall_i;
  assign adv        = in_valid_q & ~out_busy;
  assign in_stall_o = in_valid_q & out_busy;

  assign len_lookup = LEN_TABLE[wdata_q[7:3]];
  assign lfsr_fb    = lfsr_q[0] ^ (ns_tap_q ? lfsr_q[6] : lfsr_q[1]);
  assign lfsr_next  = {lfsr_fb, lfsr_q[13:1]};
  assign frame_sum  = {1'b0, frame_step_q} + 4'd1;

  always_comb begin
    p1_duty_d    = p1_duty_q;
    p1_vol_d     = p1_vol_q;
    p1_step_d    = p1_step_q;
    p1_len_d     = p1_len_q;
    p2_duty_d    = p2_duty_q;
    p2_vol_d     = p2_vol_q;
    p2_step_d    = p2_step_q;
    p2_len_d     = p2_len_q;
    tr_len_d     = tr_len_q;
    tr_step_d    = tr_step_q;
    ns_vol_d     = ns_vol_q;
    ns_tap_d     = ns_tap_q;
    ns_rate_d    = ns_rate_q;
    ns_len_d     = ns_len_q;
    lfsr_d       = lfsr_q;
    enables_d    = enables_q;
    five_mode_d  = five_mode_q;
    frame_step_d = frame_step_q;
    status_d     = '0;
    p1_lvl_d     = p1_lvl_q;
    p2_lvl_d     = p2_lvl_q;
    tr_lvl_d     = tr_lvl_q;
    ns_lvl_d     = ns_lvl_q;

    unique case (op_e'(op_q))
      OP_WRITE: begin
        unique case (off_q)
          REG_P1_CTRL: begin
            p1_duty_d = wdata_q[7:6];
            p1_vol_d  = {wdata_q[5], wdata_q[3:0]};
          end
          REG_P1_LEN: begin
            p1_len_d  = len_lookup;
            p1_step_d = '0;
          end
          REG_P2_CTRL: begin
            p2_duty_d = wdata_q[7:6];
            p2_vol_d  = {wdata_q[5], wdata_q[3:0]};
          end
          REG_P2_LEN: begin
            p2_len_d  = len_lookup;
            p2_step_d = '0;
          end
          REG_TR_LEN:  tr_len_d = len_lookup;
          REG_NS_VOL:  ns_vol_d = wdata_q[4:0];
          REG_NS_MODE: begin
            ns_tap_d  = wdata_q[7];
            ns_rate_d = wdata_q[3:0];
          end
          REG_NS_LEN:  ns_len_d = len_lookup;
          REG_ENABLES: enables_d = wdata_q[3:0];
          REG_FRAME: begin
            five_mode_d  = wdata_q[7];
            frame_step_d = FRAME_FIRST;
          end
          default: ;
        endcase
      end
      OP_STATUS: status_d = {tr_len_q != '0, p2_len_q != '0, p1_len_q != '0};
      OP_P1_CLK: begin
        p1_lvl_d = '0;
        if (enables_q[0] && p1_len_q != '0) begin
          if (DUTY_PAT[p1_duty_q][p1_step_q]) p1_lvl_d = {p1_vol_q, 1'b0};
          p1_step_d = p1_step_q + 4'd1;
        end
      end
      OP_P2_CLK: begin
        p2_lvl_d = '0;
        if (enables_q[1] && p2_len_q != '0) begin
          if (DUTY_PAT[p2_duty_q][p2_step_q]) p2_lvl_d = {p2_vol_q, 1'b0};
          p2_step_d = p2_step_q + 4'd1;
        end
      end
      OP_TR_CLK: begin
        tr_lvl_d = TRI_TABLE[tr_step_q];
        if (enables_q[2] && tr_len_q != '0) tr_step_d = tr_step_q + 5'd1;
      end
      OP_NS_CLK: begin
        lfsr_d = lfsr_next;
        // sound only on a low output bit with a usable rate
        if (enables_q[3] && ns_len_q != '0 && !lfsr_next[0] && (|ns_rate_q[3:1])) begin
          ns_lvl_d = ns_vol_q;
        end else begin
          ns_lvl_d = '0;
        end
      end
      OP_FRAME: begin
        if (p1_len_q != '0) p1_len_d = p1_len_q - 8'd1;
        if (p2_len_q != '0) p2_len_d = p2_len_q - 8'd1;
        if (tr_len_q != '0) tr_len_d = tr_len_q - 8'd1;
        if (ns_len_q != '0) ns_len_d = ns_len_q - 8'd1;
        if (five_mode_q) begin
          frame_step_d = (frame_sum >= 4'd5) ? 3'(frame_sum - 4'd5) : frame_sum[2:0];
        end else begin
          frame_step_d = {1'b0, frame_sum[1:0]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q    <= op_i;
      off_q   <= reg_offset_i;
      wdata_q <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      p1_duty_q    <= '0;
      p1_vol_q     <= P_VOL_RESET;
      p1_step_q    <= '0;
      p1_len_q     <= '0;
      p2_duty_q    <= '0;
      p2_vol_q     <= P_VOL_RESET;
      p2_step_q    <= '0;
      p2_len_q     <= '0;
      tr_len_q     <= '0;
      tr_step_q    <= '0;
      ns_vol_q     <= '0;
      ns_tap_q     <= 1'b0;
      ns_rate_q    <= '0;
      ns_len_q     <= '0;
      lfsr_q       <= LFSR_SEED;
      enables_q    <= '0;
      five_mode_q  <= 1'b0;
      frame_step_q <= FRAME_FIRST;
      status_q     <= '0;
      p1_lvl_q     <= '0;
      p2_lvl_q     <= '0;
      tr_lvl_q     <= '0;
      ns_lvl_q     <= '0;
    end else begin
      if (!out_busy) out_valid_q <= in_valid_q;
      if (adv) begin
        p1_duty_q    <= p1_duty_d;
        p1_vol_q     <= p1_vol_d;
        p1_step_q    <= p1_step_d;
        p1_len_q     <= p1_len_d;
        p2_duty_q    <= p2_duty_d;
        p2_vol_q     <= p2_vol_d;
        p2_step_q    <= p2_step_d;
        p2_len_q     <= p2_len_d;
        tr_len_q     <= tr_len_d;
        tr_step_q    <= tr_step_d;
        ns_vol_q     <= ns_vol_d;
        ns_tap_q     <= ns_tap_d;
        ns_rate_q    <= ns_rate_d;
        ns_len_q     <= ns_len_d;
        lfsr_q       <= lfsr_d;
        enables_q    <= enables_d;
        five_mode_q  <= five_mode_d;
        frame_step_q <= frame_step_d;
        status_q     <= status_d;
        p1_lvl_q     <= p1_lvl_d;
        p2_lvl_q     <= p2_lvl_d;
        tr_lvl_q     <= tr_lvl_d;
        ns_lvl_q     <= ns_lvl_d;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign pulse1_level_o = p1_lvl_q;
  assign pulse2_level_o = p2_lvl_q;
  assign tri_level_o    = tr_lvl_q;
  assign noise_level_o  = ns_lvl_q;

  // the noise register is an invertible shift, so it never reaches all zeros
  a_lfsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != '0) else $error("noise shift register reached zero");

  a_status_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && op_q != OP_STATUS |=> status_o == '0)
    else $error("status set on a transfer that is not a read");

  a_frame_counts_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && op_q == OP_FRAME && p1_len_q != '0 |=> p1_len_q == $past(p1_len_q) - 8'd1)
    else $error("pulse 1 length did not count down on a frame tick");

  a_no_advance_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> $stable(lfsr_q) && $stable(p1_len_q) && $stable(tr_step_q))
    else $error("channel state moved while the result was stalled");

endmodule

`default_nettype wire
